### rtl/mbcrc_pkg.sv
// ----------------------------------------------------------------------------
// Modbus CRC-16 engine package
// Shared codes, register indexes and reset values for the CRC engine.
// ----------------------------------------------------------------------------
package mbcrc_pkg;

    localparam int MAX_FRAME_LEN_DEFAULT = 256;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE          = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_FRAME_LEN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_VALUE    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLYNOMIAL    = 2'd3;

    localparam logic [1:0] MODE_COMPUTE  = 2'd0;
    localparam logic [1:0] MODE_VALIDATE = 2'd1;
    localparam logic [1:0] MODE_APPEND   = 2'd2;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_CRC     = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [8:0]  RESET_MIN_FRAME_LEN = 9'd4;
    localparam logic [8:0]  MIN_FRAME_FLOOR     = 9'd3;
    localparam logic [15:0] RESET_INIT_VALUE    = 16'hFFFF;
    localparam logic [15:0] RESET_POLYNOMIAL    = 16'hA001;

endpackage

### rtl/modbus_crc16_engine.sv
// ----------------------------------------------------------------------------
// Modbus CRC-16 engine
// Streams frame bytes through a reflected CRC-16 in compute, validate or
// append mode.
// ----------------------------------------------------------------------------
// Bytes arrive on the byte channel (data_byte, last_byte) and are taken at a
// clock edge where byte_valid is high and byte_stall is low. Results leave on
// the result channel under result_valid and result_stall in the same way.
// Configuration is written through cfg_valid, cfg_ready, cfg_index and
// cfg_data while the engine is idle, a rule on the user that the block does
// not enforce; cfg_ready is always high. A byte is registered on entry and,
// once the result register is free, folded into the CRC by an eight-step
// combinational update. One byte is taken per cycle while byte_stall is low.
// A byte that ends a frame in append mode yields three result beats (echo,
// CRC low, CRC high), and the input stalls for the two extra beats.
// When the receiver stalls, the pending result holds and the entry register
// stalls the byte channel once it is full.
// Reset clears the frame state and loads the register defaults: compute mode,
// minimum length 4, init value 0xFFFF, polynomial 0xA001.
// ----------------------------------------------------------------------------
module modbus_crc16_engine
#(
    parameter int MAX_FRAME_LEN = mbcrc_pkg::MAX_FRAME_LEN_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbcrc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbcrc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              byte_valid,
    output logic                              byte_stall,
    input  logic [7:0]                        data_byte,
    input  logic                              last_byte,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [1:0]                        result_kind,
    output logic [7:0]                        out_byte,
    output logic [15:0]                       crc_value,
    output logic                              frame_good,
    output logic                              too_short,
    output logic                              last_result
);

    import mbcrc_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_LEN);

    logic [1:0]       mode_reg;
    logic [8:0]       min_len_reg;
    logic [15:0]      init_reg;
    logic [15:0]      poly_reg;

    logic             s1_valid_reg, s1_valid_next;
    logic [7:0]       s1_byte_reg;
    logic             s1_last_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       held0_reg, held0_next;
    logic [7:0]       held1_reg, held1_next;

    logic             grp_valid_reg, grp_valid_next;
    logic [1:0]       grp_idx_reg, grp_idx_next;
    logic [1:0]       grp_last_reg;
    logic [1:0]       grp_kind_reg;
    logic [7:0]       grp_byte_reg;
    logic [15:0]      grp_crc_reg;
    logic             grp_good_reg;
    logic             grp_short_reg;

    logic             byte_fire;
    logic             s1_fire;
    logic             out_fire;
    logic             grp_done;
    logic             grp_free;
    logic             grp_load;

    logic [15:0]      crc_start;
    logic [7:0]       upd_byte;
    logic [15:0]      upd_crc;
    logic [CNT_W-1:0] len;
    logic [8:0]       minimum;
    logic             len_short;
    logic [15:0]      rx_crc;

    logic [1:0]       ld_last;
    logic [1:0]       ld_kind;
    logic [7:0]       ld_byte;
    logic             ld_good;
    logic             ld_short;
    logic             ld_produce;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_COMPUTE;
            min_len_reg <= RESET_MIN_FRAME_LEN;
            init_reg    <= RESET_INIT_VALUE;
            poly_reg    <= RESET_POLYNOMIAL;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE:          mode_reg    <= cfg_data[1:0];
                CFG_MIN_FRAME_LEN: min_len_reg <= cfg_data[8:0];
                CFG_INIT_VALUE:    init_reg    <= cfg_data;
                CFG_POLYNOMIAL:    poly_reg    <= cfg_data;
                default:           mode_reg    <= mode_reg;
            endcase
        end
    end

    assign out_fire   = grp_valid_reg && !result_stall;
    assign grp_done   = out_fire && (grp_idx_reg == grp_last_reg);
    assign grp_free   = !grp_valid_reg || grp_done;
    assign s1_fire    = s1_valid_reg && grp_free;
    assign byte_stall = s1_valid_reg && !grp_free;
    assign byte_fire  = byte_valid && !byte_stall;

    assign s1_valid_next = byte_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_fire)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    assign crc_start = (count_reg == '0) ? init_reg : crc_reg;
    assign upd_byte  = (mode_reg == MODE_VALIDATE) ? held0_reg : s1_byte_reg;

    mbcrc_byte_update u_byte_update
    (
        .crc_in  (crc_start),
        .data    (upd_byte),
        .poly    (poly_reg),
        .crc_out (upd_crc)
    );

    always_comb
    begin
        if (mode_reg == MODE_VALIDATE)
        begin
            crc_next = (count_reg >= CNT_W'(2)) ? upd_crc : crc_start;
        end
        else
        begin
            crc_next = upd_crc;
        end
    end

    assign len       = (count_reg < CNT_MAX) ? count_reg + CNT_W'(1) : CNT_MAX;
    assign minimum   = (min_len_reg > MIN_FRAME_FLOOR) ? min_len_reg : MIN_FRAME_FLOOR;
    assign len_short = CMP_W'(len) < CMP_W'(minimum);
    assign rx_crc    = {s1_byte_reg, held1_reg};

    always_comb
    begin
        count_next = len;
        held0_next = held1_reg;
        held1_next = s1_byte_reg;
        if (s1_last_reg)
        begin
            count_next = '0;
            held0_next = 8'h00;
            held1_next = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= RESET_INIT_VALUE;
            held0_reg <= 8'h00;
            held1_reg <= 8'h00;
        end
        else if (s1_fire)
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

    always_comb
    begin
        ld_last    = 2'd0;
        ld_kind    = KIND_CRC;
        ld_byte    = 8'h00;
        ld_good    = 1'b0;
        ld_short   = 1'b0;
        ld_produce = s1_last_reg;
        case (mode_reg)
            MODE_APPEND:
            begin
                ld_kind    = KIND_BYTE;
                ld_byte    = s1_byte_reg;
                ld_last    = s1_last_reg ? 2'd2 : 2'd0;
                ld_produce = 1'b1;
            end
            MODE_VALIDATE:
            begin
                ld_kind  = KIND_VERDICT;
                ld_short = len_short;
                ld_good  = !len_short && (rx_crc == crc_next);
            end
            default:
            begin
                ld_kind = KIND_CRC;
            end
        endcase
    end

    assign grp_load = s1_fire && ld_produce;

    always_comb
    begin
        grp_valid_next = grp_valid_reg;
        grp_idx_next   = grp_idx_reg;
        if (grp_load)
        begin
            grp_valid_next = 1'b1;
            grp_idx_next   = 2'd0;
        end
        else if (grp_done)
        begin
            grp_valid_next = 1'b0;
        end
        else if (out_fire)
        begin
            grp_idx_next = grp_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            grp_idx_reg   <= 2'd0;
            grp_last_reg  <= 2'd0;
        end
        else
        begin
            grp_valid_reg <= grp_valid_next;
            grp_idx_reg   <= grp_idx_next;
            if (grp_load)
            begin
                grp_last_reg <= ld_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_load)
        begin
            grp_kind_reg  <= ld_kind;
            grp_byte_reg  <= ld_byte;
            grp_crc_reg   <= crc_next;
            grp_good_reg  <= ld_good;
            grp_short_reg <= ld_short;
        end
    end

    assign result_valid = grp_valid_reg;
    assign result_kind  = grp_kind_reg;
    assign frame_good   = grp_good_reg;
    assign too_short    = grp_short_reg;
    assign last_result  = (grp_idx_reg == grp_last_reg);

    always_comb
    begin
        case (grp_idx_reg)
            2'd1:    out_byte = grp_crc_reg[7:0];
            2'd2:    out_byte = grp_crc_reg[15:8];
            default: out_byte = grp_byte_reg;
        endcase
        if ((grp_kind_reg == KIND_BYTE) && (grp_idx_reg == 2'd0))
        begin
            crc_value = 16'h0000;
        end
        else
        begin
            crc_value = grp_crc_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg |-> (grp_idx_reg <= grp_last_reg))
        else $error("result index ran past the end of its group");

    assert property (@(posedge clk) disable iff (!rst_n)
        (grp_valid_reg && (grp_last_reg != 2'd0)) |-> (grp_kind_reg == KIND_BYTE))
        else $error("multi-beat group outside append mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> s1_valid_reg)
        else $error("byte channel stalled with an empty entry register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (count_reg == '0))
        else $error("byte count not cleared after the frame end");

endmodule

### rtl/mbcrc_byte_update.sv
// ----------------------------------------------------------------------------
// CRC byte update
// Folds one byte into a reflected CRC-16 value: eight LSB-first shift and
// conditional polynomial steps.
// ----------------------------------------------------------------------------
module mbcrc_byte_update
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    input  logic [15:0] poly,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (acc[0])
            begin
                acc = (acc >> 1) ^ poly;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
        crc_out = acc;
    end

endmodule

### tb/sv/modbus_crc16_engine_test.sv
// ----------------------------------------------------------------------------
// Modbus CRC-16 engine testbench
// Drives byte frames through compute, validate, append and the unused mode
// code, predicts every result beat from a CRC model kept in the bench, and
// compares each beat field by field while both channels idle and stall at
// random and the receiver holds off long enough to back up the engine.
// ----------------------------------------------------------------------------
module modbus_crc16_engine_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mbcrc_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int FRAME_LEN_CAP = MAX_FRAME_LEN_DEFAULT;
    localparam int ENGINE_LATENCY = 4;
    localparam int RANDOM_BYTES = 80;
    localparam int LONG_FRAME_LEN = 40;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] crc;
        logic        good;
        logic        short_frame;
        logic        last;
    } crc_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   byte_valid;
    logic                   byte_stall;
    logic [7:0]             data_byte;
    logic                   last_byte;
    logic                   result_valid;
    logic                   result_stall;
    logic [1:0]             result_kind;
    logic [7:0]             out_byte;
    logic [15:0]            crc_value;
    logic                   frame_good;
    logic                   too_short;
    logic                   last_result;

    logic [1:0]  cur_mode = MODE_COMPUTE;
    logic [8:0]  cur_min_len = RESET_MIN_FRAME_LEN;
    logic [15:0] cur_init = RESET_INIT_VALUE;
    logic [15:0] cur_poly = RESET_POLYNOMIAL;
    logic [15:0] run_crc = RESET_INIT_VALUE;
    logic [8:0]  run_count = '0;
    logic [7:0]  held [0:1] = '{8'h00, 8'h00};

    crc_result_t awaited_beats[$];
    logic [7:0]  frame_buf[$];

    bit no_idle = 1'b0;
    int hold_request = 0;
    int holds_done = 0;
    int errors = 0;
    int bytes_sent = 0;
    int frames_done = 0;
    int beats_checked = 0;
    int good_verdicts = 0;
    int short_verdicts = 0;
    int bad_verdicts = 0;

    modbus_crc16_engine DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_kind  (result_kind),
        .out_byte     (out_byte),
        .crc_value    (crc_value),
        .frame_good   (frame_good),
        .too_short    (too_short),
        .last_result  (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] fold_crc_byte(input logic [15:0] crc_in,
                                                  input logic [7:0] value);
        logic [15:0] c;
        c = crc_in ^ {8'h00, value};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ cur_poly) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void predict_byte(input logic [7:0] value, input logic end_mark);
        logic [8:0]  prior;
        logic [15:0] crc;
        logic [8:0]  floor_len;
        crc_result_t beat;
        prior = run_count;
        crc = (prior == 0) ? cur_init : run_crc;
        if (cur_mode == MODE_VALIDATE)
        begin
            if (prior >= 2)
                crc = fold_crc_byte(crc, held[0]);
        end
        else
        begin
            crc = fold_crc_byte(crc, value);
        end
        held[0] = held[1];
        held[1] = value;
        run_crc = crc;
        run_count = (prior < FRAME_LEN_CAP) ? prior + 9'd1 : 9'(FRAME_LEN_CAP);
        case (cur_mode)
            MODE_APPEND:
            begin
                beat = {KIND_BYTE, value, 16'h0000, 1'b0, 1'b0, ~end_mark};
                awaited_beats.push_back(beat);
                if (end_mark)
                begin
                    beat = {KIND_BYTE, crc[7:0], crc, 1'b0, 1'b0, 1'b0};
                    awaited_beats.push_back(beat);
                    beat = {KIND_BYTE, crc[15:8], crc, 1'b0, 1'b0, 1'b1};
                    awaited_beats.push_back(beat);
                end
            end
            MODE_VALIDATE:
            begin
                if (end_mark)
                begin
                    floor_len = (cur_min_len > MIN_FRAME_FLOOR) ? cur_min_len : MIN_FRAME_FLOOR;
                    if (run_count < floor_len)
                    begin
                        beat = {KIND_VERDICT, 8'h00, crc, 1'b0, 1'b1, 1'b1};
                        short_verdicts++;
                    end
                    else
                    begin
                        beat = {KIND_VERDICT, 8'h00, crc, ({held[1], held[0]} == crc), 1'b0,
                                1'b1};
                        if (beat.good)
                            good_verdicts++;
                        else
                            bad_verdicts++;
                    end
                    awaited_beats.push_back(beat);
                end
            end
            default:
            begin
                if (end_mark)
                begin
                    beat = {KIND_CRC, 8'h00, crc, 1'b0, 1'b0, 1'b1};
                    awaited_beats.push_back(beat);
                end
            end
        endcase
        if (end_mark)
        begin
            run_crc = cur_init;
            run_count = '0;
            held[0] = 8'h00;
            held[1] = 8'h00;
            frames_done++;
        end
    endfunction

    function automatic string show(input crc_result_t r);
        return $sformatf("kind=%0d out=%02h crc=%04h good=%0b short=%0b last=%0b",
                         r.kind, r.data, r.crc, r.good, r.short_frame, r.last);
    endfunction

    always @(posedge clk)
    begin : result_check
        crc_result_t got;
        crc_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = {result_kind, out_byte, crc_value, frame_good, too_short, last_result};
            if (awaited_beats.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result beat with none expected: %s", show(got));
            end
            else
            begin
                want = awaited_beats.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: beat %0d expected %s, got %s",
                                 beats_checked, show(want), show(got));
                end
            end
            beats_checked++;
        end
    end

    initial
    begin : result_stall_driver
        int span;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                span = hold_request;
                hold_request = 0;
                result_stall <= 1'b1;
                repeat (span) @(posedge clk);
                holds_done++;
            end
            else
            begin
                result_stall <= (!no_idle && $urandom_range(99) < 23);
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:          cur_mode = value[1:0];
            CFG_MIN_FRAME_LEN: cur_min_len = value[8:0];
            CFG_INIT_VALUE:
            begin
                cur_init = value;
                if (run_count == 0)
                    run_crc = value;
            end
            CFG_POLYNOMIAL:    cur_poly = value;
            default:           ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] m, input logic [8:0] min_len,
                              input logic [15:0] init, input logic [15:0] poly);
        write_reg(CFG_MODE, {14'h0000, m});
        write_reg(CFG_MIN_FRAME_LEN, {7'h00, min_len});
        write_reg(CFG_INIT_VALUE, init);
        write_reg(CFG_POLYNOMIAL, poly);
    endtask

    task automatic send_byte(input logic [7:0] value, input logic end_mark);
        while (!no_idle && $urandom_range(99) < 23)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte <= value;
        last_byte <= end_mark;
        do @(posedge clk); while (byte_stall);
        predict_byte(value, end_mark);
        bytes_sent++;
    endtask

    task automatic send_frame;
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic settle_engine;
        byte_valid <= 1'b0;
        while (awaited_beats.size() != 0)
            @(posedge clk);
        repeat (ENGINE_LATENCY) @(posedge clk);
    endtask

    task automatic fill_random(input int n);
        frame_buf.delete();
        repeat (n) frame_buf.push_back(8'($urandom_range(255)));
    endtask

    task automatic append_crc;
        logic [15:0] c;
        c = cur_init;
        foreach (frame_buf[i])
            c = fold_crc_byte(c, frame_buf[i]);
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endtask

    task automatic test_reset_defaults;
        frame_buf = '{8'h00};
        send_frame();
        frame_buf = '{8'hFF, 8'h80, 8'h7F};
        send_frame();
        settle_engine();
        write_reg(CFG_MODE, {14'h0000, MODE_UNUSED});
        frame_buf = '{8'hA5, 8'h5A};
        send_frame();
        settle_engine();
    endtask

    task automatic test_append_mode;
        set_config(MODE_APPEND, RESET_MIN_FRAME_LEN, RESET_INIT_VALUE, RESET_POLYNOMIAL);
        frame_buf = '{8'h00, 8'hFF, 8'h5A};
        send_frame();
        frame_buf = '{8'hC3};
        send_frame();
        settle_engine();
    endtask

    task automatic test_validate_mode;
        set_config(MODE_VALIDATE, RESET_MIN_FRAME_LEN, RESET_INIT_VALUE, RESET_POLYNOMIAL);
        frame_buf = '{8'h12, 8'h34};
        append_crc();
        send_frame();
        frame_buf[3] = frame_buf[3] ^ 8'h80;
        send_frame();
        frame_buf = '{8'hAB, 8'hCD, 8'hEF};
        send_frame();
        frame_buf = '{8'h5A};
        send_frame();
        settle_engine();
        // A minimum below three still rejects anything shorter than three bytes.
        write_reg(CFG_MIN_FRAME_LEN, 16'd2);
        frame_buf = '{8'hAB, 8'hCD};
        send_frame();
        frame_buf = '{8'hAB};
        append_crc();
        send_frame();
        settle_engine();
    endtask

    task automatic test_mode_switch_in_frame;
        set_config(MODE_COMPUTE, RESET_MIN_FRAME_LEN, RESET_INIT_VALUE, RESET_POLYNOMIAL);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        settle_engine();
        write_reg(CFG_MODE, {14'h0000, MODE_VALIDATE});
        write_reg(CFG_INIT_VALUE, 16'h1234);
        send_byte(8'h44, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'h66, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'h88, 1'b0);
        settle_engine();
        write_reg(CFG_MODE, {14'h0000, MODE_APPEND});
        send_byte(8'h99, 1'b1);
        settle_engine();
    endtask

    task automatic test_register_extremes;
        set_config(MODE_COMPUTE, 9'd3, 16'h0000, 16'h0000);
        frame_buf = '{8'hFF, 8'h01};
        send_frame();
        settle_engine();
        set_config(MODE_APPEND, 9'd256, 16'hFFFF, 16'hFFFF);
        frame_buf = '{8'h80, 8'h00};
        send_frame();
        settle_engine();
    endtask

    task automatic test_long_frames;
        set_config(MODE_VALIDATE, 9'(LONG_FRAME_LEN), RESET_INIT_VALUE, RESET_POLYNOMIAL);
        fill_random(LONG_FRAME_LEN - 2);
        append_crc();
        send_frame();
        // One byte under the minimum fails as too short even with a correct CRC.
        fill_random(LONG_FRAME_LEN - 3);
        append_crc();
        send_frame();
        settle_engine();
    endtask

    task automatic test_back_pressure;
        set_config(MODE_APPEND, RESET_MIN_FRAME_LEN, RESET_INIT_VALUE, RESET_POLYNOMIAL);
        no_idle = 1'b1;
        hold_request = 80;
        repeat (3)
        begin
            fill_random(8);
            send_frame();
        end
        settle_engine();
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic;
        int start;
        int phase;
        int r;
        logic [1:0] m;
        logic [8:0] min_len;
        logic [15:0] init;
        logic [15:0] poly;
        int k;
        start = bytes_sent;
        phase = 0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            r = $urandom_range(99);
            m = (r < 40) ? MODE_VALIDATE : (r < 65) ? MODE_APPEND :
                (r < 90) ? MODE_COMPUTE : MODE_UNUSED;
            r = $urandom_range(99);
            min_len = (r < 5) ? 9'd256 : (r < 20) ? MIN_FRAME_FLOOR : 9'($urandom_range(3, 8));
            r = $urandom_range(99);
            init = (r < 20) ? 16'h0000 : (r < 40) ? 16'hFFFF : 16'($urandom_range(65535));
            r = $urandom_range(99);
            poly = (r < 15) ? 16'h0000 : (r < 30) ? 16'hFFFF :
                   (r < 50) ? RESET_POLYNOMIAL : 16'($urandom_range(65535));
            set_config(m, min_len, init, poly);
            no_idle = (phase == 1);
            repeat ($urandom_range(2, 5))
            begin
                r = $urandom_range(99);
                if (cur_mode == MODE_VALIDATE && r < 85)
                begin
                    fill_random($urandom_range(1, 8));
                    append_crc();
                    if (r >= 70)
                    begin
                        k = $urandom_range(frame_buf.size() - 1);
                        frame_buf[k] = frame_buf[k] ^ (8'h01 << $urandom_range(7));
                    end
                end
                else
                begin
                    fill_random((r < 10) ? $urandom_range(20, 40) : $urandom_range(1, 10));
                end
                send_frame();
            end
            settle_engine();
            phase++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MODE;
        cfg_data <= '0;
        byte_valid <= 1'b0;
        data_byte <= 8'h00;
        last_byte <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_append_mode();
        test_validate_mode();
        test_mode_switch_in_frame();
        test_register_extremes();
        test_long_frames();
        test_back_pressure();
        test_random_traffic();
        settle_engine();

        if (awaited_beats.size() != 0)
        begin
            errors++;
            $display("ERROR: %0d expected result beats never arrived", awaited_beats.size());
        end
        $display("Covered %0d bytes in %0d frames, %0d result beats checked, %0d long holds.",
                 bytes_sent, frames_done, beats_checked, holds_done);
        $display("Validate verdicts: %0d good, %0d too short, %0d CRC mismatch.",
                 good_verdicts, short_verdicts, bad_verdicts);
        if (errors == 0)
            $display("modbus_crc16_engine_test: done, clean");
        else
            $display("modbus_crc16_engine_test: done, errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d result beats still expected.", awaited_beats.size());
        $display("modbus_crc16_engine_test: done, errors");
        $finish;
    end

endmodule

### modbus_crc16_engine.f
rtl/mbcrc_pkg.sv
rtl/mbcrc_byte_update.sv
rtl/modbus_crc16_engine.sv
tb/sv/modbus_crc16_engine_test.sv
